[src/gcs_pkg.sv]
// Package: constants, configuration and request types for the packed 3D cell store.
package gcs_pkg;

	localparam int MEM_BYTES = 65536;
	localparam int MAX_DIM   = 1024;

	localparam int DIM_W   = 11;
	localparam int CB_W    = 3;
	localparam int COORD_W = 12;
	localparam int DATA_W  = 32;
	localparam int BYTE_W  = 8;
	localparam int CB_MAX  = 4;

	localparam int LANES  = 4;
	localparam int LANE_W = $clog2(LANES);
	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam int ROWS   = MEM_BYTES / LANES;
	localparam int ROW_W  = $clog2(ROWS);

	localparam int T1_W  = 2 * DIM_W + 1;
	localparam int T2_W  = T1_W + DIM_W + 1;
	localparam int IDX_W = T2_W + CB_W;

	localparam int S_TDATA_W = 72;
	localparam int CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_CELL_BYTES  = CFG_IDX_W'(3);

	localparam logic KIND_READ  = 1'b0;
	localparam logic KIND_WRITE = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] depth;
		logic [CB_W-1:0]  cb;
	} grid_cfg_t;

	typedef struct packed {
		logic              valid;
		logic              write;
		logic              bad;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic [CB_W-1:0]   cb;
	} mem_req_t;

	typedef struct packed {
		logic              valid;
		logic              bad;
		logic [DATA_W-1:0] rdata;
	} mem_rsp_t;

	// non-negative and below the limit
	function automatic logic coord_ok(input logic [COORD_W-1:0] c, input logic [DIM_W-1:0] lim);
		coord_ok = !c[COORD_W-1] && (c[DIM_W-1:0] < lim);
	endfunction

endpackage

[src/gcs_ram.sv]
// Generic single-port RAM with registered read.
module gcs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[src/gcs_agu.sv]
// Address generation: bounds check and byte index, three registered stages.
module gcs_agu (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gcs_pkg::grid_cfg_t           cfg,
	input  logic                         in_valid,
	input  logic                         in_write,
	input  logic [gcs_pkg::COORD_W-1:0]  coord_x,
	input  logic [gcs_pkg::COORD_W-1:0]  coord_y,
	input  logic [gcs_pkg::COORD_W-1:0]  coord_z,
	input  logic [gcs_pkg::DATA_W-1:0]   write_data,
	output gcs_pkg::mem_req_t            req
);
	import gcs_pkg::*;

	logic              valid_s1, valid_s2, valid_s3;
	logic              write_s1, write_s2, write_s3;
	logic              bad_s1, bad_s2, bad_s3;
	logic [DATA_W-1:0] data_s1, data_s2, data_s3;
	logic [DIM_W-1:0]  x_s1;
	logic [T1_W-1:0]   t1_s1;
	logic [T2_W-1:0]   t2_s2;
	logic [IDX_W-1:0]  idx_s3;
	logic [IDX_W:0]    end_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		write_s1 <= in_write;
		data_s1  <= write_data;
		bad_s1   <= !coord_ok(coord_x, cfg.width) || !coord_ok(coord_y, cfg.height) ||
			!coord_ok(coord_z, cfg.depth);
		x_s1     <= coord_x[DIM_W-1:0];
		t1_s1    <= T1_W'(coord_z[DIM_W-1:0]) * T1_W'(cfg.height) + T1_W'(coord_y[DIM_W-1:0]);

		write_s2 <= write_s1;
		data_s2  <= data_s1;
		bad_s2   <= bad_s1;
		t2_s2    <= T2_W'(t1_s1) * T2_W'(cfg.width) + T2_W'(x_s1);

		write_s3 <= write_s2;
		data_s3  <= data_s2;
		bad_s3   <= bad_s2;
		idx_s3   <= IDX_W'(t2_s2) * IDX_W'(cfg.cb);
	end

	// cell must end inside the memory
	assign end_s3 = (IDX_W+1)'(idx_s3) + (IDX_W+1)'(cfg.cb);

	always_comb begin
		req.valid = valid_s3;
		req.write = write_s3;
		req.bad   = bad_s3 || (end_s3 > (IDX_W+1)'(MEM_BYTES));
		req.addr  = idx_s3[ADDR_W-1:0];
		req.data  = data_s3;
		req.cb    = cfg.cb;
	end

endmodule

[src/gcs_lanes.sv]
// Byte-lane memory banks: lane mapping, read assembly and clearing sweep.
module gcs_lanes (
	input  logic               clk,
	input  logic               arst_n,
	input  gcs_pkg::mem_req_t  req,
	output gcs_pkg::mem_rsp_t  rsp,
	output logic               clearing
);
	import gcs_pkg::*;

	logic                clr_q;
	logic [ROW_W-1:0]    clr_row_q;
	logic [LANE_W-1:0]   off    [LANES];
	logic [ADDR_W-1:0]   lsum   [LANES];
	logic                lane_en[LANES];
	logic                we     [LANES];
	logic [ROW_W-1:0]    row    [LANES];
	logic [BYTE_W-1:0]   wbyte  [LANES];
	logic [BYTE_W-1:0]   rbyte  [LANES];
	logic                valid_s1, bad_s1, write_s1;
	logic [LANE_W-1:0]   a0_s1;
	logic [CB_W-1:0]     cb_s1;
	logic [LANE_W-1:0]   src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_row_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_row_q == ROW_W'(ROWS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1 <= req.valid;
		end
	end

	assign clearing = clr_q;

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		always_comb begin
			off[b]     = LANE_W'(b) - req.addr[LANE_W-1:0];
			lsum[b]    = req.addr + ADDR_W'(off[b]);
			lane_en[b] = (CB_W'(off[b]) < req.cb);
			if (clr_q) begin
				we[b]    = 1'b1;
				row[b]   = clr_row_q;
				wbyte[b] = '0;
			end else begin
				we[b]    = req.valid && req.write && !req.bad && lane_en[b];
				row[b]   = lsum[b][ADDR_W-1:LANE_W];
				wbyte[b] = BYTE_W'(req.data >> (BYTE_W * off[b]));
			end
		end

		gcs_ram #(
			.WIDTH(BYTE_W),
			.DEPTH(ROWS)
		) u_ram (
			.clk  (clk),
			.we   (we[b]),
			.addr (row[b]),
			.wdata(wbyte[b]),
			.rdata(rbyte[b])
		);
	end

	always_ff @(posedge clk) begin
		bad_s1   <= req.bad;
		write_s1 <= req.write;
		a0_s1    <= req.addr[LANE_W-1:0];
		cb_s1    <= req.cb;
	end

	// byte i of the cell sits in lane (a0 + i) mod LANES
	always_comb begin
		rsp.valid = valid_s1;
		rsp.bad   = bad_s1;
		rsp.rdata = '0;
		src       = '0;
		for (int i = 0; i < CB_MAX; i++) begin
			src = a0_s1 + LANE_W'(i);
			if (CB_W'(i) < cb_s1 && !bad_s1 && !write_s1) begin
				rsp.rdata[i*BYTE_W +: BYTE_W] = rbyte[src];
			end
		end
	end

endmodule

[src/grid3d_packed_cell_store.sv]
// Top level: stream ports, configuration registers, output holding.
// An accepted word's result passes three address stages, the bank read and output registers.
// One word at a time: s_tready stays low from acceptance until the result enters the output
// register, held off by the address multiplies (three stages), the bank read and m_tready.
// Reset: registers to width/height/depth 1 and 4 bytes per cell, then a clearing sweep of
// all 16384 rows (one row of all byte lanes per cycle) before s_tready rises.
module grid3d_packed_cell_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// coord_x[11:0], coord_y[23:12], coord_z[35:24], write_data[67:36], zero pad
	input  logic [gcs_pkg::S_TDATA_W-1:0]   s_tdata,
	// kind[0]
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_data[31:0]
	output logic [gcs_pkg::DATA_W-1:0]      m_tdata,
	// out_of_range[0]
	output logic                            m_tuser,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [gcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gcs_pkg::DIM_W-1:0]       cfg_data
);
	import gcs_pkg::*;

	grid_cfg_t         cfg_q;
	mem_req_t          req;
	mem_rsp_t          rsp;
	logic              clearing;
	logic              busy_q;
	logic              accept;
	logic              out_free;
	logic              m_tvalid_q, m_tuser_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              pend_valid_q, pend_bad_q;
	logic [DATA_W-1:0] pend_data_q;
	logic [DIM_W-1:0]  dim_sat;
	logic [CB_W-1:0]   cb_sat;

	assign cfg_ready = 1'b1;
	assign s_tready  = !busy_q && !clearing;
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;

	always_comb begin
		dim_sat = cfg_data;
		if (32'(cfg_data) > 32'(MAX_DIM)) begin
			dim_sat = DIM_W'(MAX_DIM);
		end
		cb_sat = cfg_data[CB_W-1:0];
		if (cb_sat == '0) begin
			cb_sat = CB_W'(1);
		end else if (cb_sat > CB_W'(CB_MAX)) begin
			cb_sat = CB_W'(CB_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= DIM_W'(1);
			cfg_q.height <= DIM_W'(1);
			cfg_q.depth  <= DIM_W'(1);
			cfg_q.cb     <= CB_W'(CB_MAX);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_WIDTH:  cfg_q.width  <= dim_sat;
				REG_GRID_HEIGHT: cfg_q.height <= dim_sat;
				REG_GRID_DEPTH:  cfg_q.depth  <= dim_sat;
				REG_CELL_BYTES:  cfg_q.cb     <= cb_sat;
				default: ;
			endcase
		end
	end

	gcs_agu u_agu (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (accept),
		.in_write  (s_tuser == KIND_WRITE),
		.coord_x   (s_tdata[COORD_W-1:0]),
		.coord_y   (s_tdata[2*COORD_W-1:COORD_W]),
		.coord_z   (s_tdata[3*COORD_W-1:2*COORD_W]),
		.write_data(s_tdata[3*COORD_W+DATA_W-1:3*COORD_W]),
		.req       (req)
	);

	gcs_lanes u_lanes (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.clearing(clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			m_tvalid_q   <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (out_free && (pend_valid_q || rsp.valid)) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				m_tvalid_q   <= pend_valid_q || rsp.valid;
				pend_valid_q <= 1'b0;
			end else if (rsp.valid) begin
				pend_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				m_tdata_q <= pend_data_q;
				m_tuser_q <= pend_bad_q;
			end else begin
				m_tdata_q <= rsp.rdata;
				m_tuser_q <= rsp.bad;
			end
		end else if (rsp.valid) begin
			pend_data_q <= rsp.rdata;
			pend_bad_q  <= rsp.bad;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("word accepted while another is in flight");

	a_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> busy_q)
		else $error("bank response without a word in flight");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> m_tvalid_q)
		else $error("held result while output register empty");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && m_tuser_q) |-> (m_tdata_q == '0))
		else $error("flagged access returned nonzero data");

endmodule
